[src/block_bump_pool_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bump pool allocator.
// Defining ASSERT_OFF turns every assertion below into an empty statement.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUMP_POOL_ALLOCATOR_DEFINES_SVH
`define BLOCK_BUMP_POOL_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("allocator assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

[src/bbpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpa_pkg
// Types, codes and constants shared by the bump pool allocator modules.
// ----------------------------------------------------------------------------
package bbpa_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  // Alignment of aligned requests; must be a power of two.
  localparam int ALIGN_BYTES    = 32;
  localparam int SMALL_LIMIT    = 4095;
  localparam int FAIL_THRESHOLD = 4;
  localparam int FAIL_MAX       = 7;
  localparam logic [14:0] POOL_SIZE_RST = 15'd4096;

  localparam logic [1:0] OP_ALIGNED   = 2'd0;
  localparam logic [1:0] OP_UNALIGNED = 2'd1;
  localparam logic [1:0] OP_RESET     = 2'd2;
  localparam logic [1:0] OP_NOP       = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_BLOCK  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] request_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  block_index;
    logic [13:0] byte_offset;
    logic        opened_block;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic step_next;
    logic grant;
    logic full;
    logic walk_init;
    logic walk_step;
    logic append;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_search;
    logic fits;
    logic last;
    logic table_full;
    logic walk_none;
    logic walk_last;
    logic out_free;
  } sts_t;

endpackage

[src/bbpa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpa_ctrl
// Sequencer for the allocator: search, fail-count walk, append and response.
// ----------------------------------------------------------------------------
module bbpa_ctrl
  import bbpa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic cfg_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SRD    = 3'd1;
  localparam logic [2:0] S_SCK    = 3'd2;
  localparam logic [2:0] S_WRD    = 3'd3;
  localparam logic [2:0] S_WCK    = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.start_search ? S_SRD : S_RESP;
        end
      end
      S_SRD: begin
        state_d = S_SCK;
      end
      S_SCK: begin
        if (sts_i.fits) begin
          cmd_o.grant = 1'b1;
          state_d = S_RESP;
        end else if (!sts_i.last) begin
          cmd_o.step_next = 1'b1;
          state_d = S_SRD;
        end else if (sts_i.table_full) begin
          cmd_o.full = 1'b1;
          state_d = S_RESP;
        end else begin
          cmd_o.walk_init = 1'b1;
          state_d = sts_i.walk_none ? S_APPEND : S_WRD;
        end
      end
      S_WRD: begin
        state_d = S_WCK;
      end
      S_WCK: begin
        cmd_o.walk_step = 1'b1;
        state_d = sts_i.walk_last ? S_APPEND : S_WRD;
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[src/bbpa_dp.sv]
`timescale 1ns / 1ps
`include "block_bump_pool_allocator_defines.svh"
// ----------------------------------------------------------------------------
// bbpa_dp
// Allocator datapath: block tables, fit test, pointers and output register.
// ----------------------------------------------------------------------------
module bbpa_dp
  import bbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_data_i,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output out_item_t   out_data_o
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [15:0] ALIGN_M1 = 16'(ALIGN_BYTES - 1);

  // Tables with a registered read port, both read at the search and walk pointer.
  logic [14:0] used_mem [MAX_BLOCKS];
  logic [2:0]  fail_mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] used_vld_q, used_vld_d;
  logic [MAX_BLOCKS-1:0] fail_vld_q, fail_vld_d;
  logic [14:0] used_rd_q;
  logic [2:0]  fail_rd_q;
  logic        used_rd_vld_q, fail_rd_vld_q;

  logic [14:0]      pool_q, pool_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] blk_q, blk_d;
  logic [IDX_W-1:0] ncur_q, ncur_d;
  logic             aligned_q, aligned_d;
  logic [11:0]      req_q, req_d;
  out_item_t        res_q, res_d;
  out_item_t        out_q;
  logic             out_valid_q, out_valid_d;

  logic             used_we, fail_we;
  logic [IDX_W-1:0] used_wa, fail_wa;
  logic [14:0]      used_wd;
  logic [2:0]       fail_wd;

  logic [14:0]      limit;
  logic             is_alloc, too_large;
  logic [15:0]      used_cur, start;
  logic [16:0]      room;
  logic [14:0]      new_used;
  logic [2:0]       fail_old, fail_inc;
  logic [CNT_W-1:0] blk_ext, cur_ext;
  logic [IDX_W-1:0] app_idx;

  // ---------------------------------------------------------------- tables
  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_rd_q <= used_mem[blk_q];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) begin
      fail_mem[fail_wa] <= fail_wd;
    end
    fail_rd_q <= fail_mem[blk_q];
  end

  // ---------------------------------------------------------------- fit test
  assign used_cur = used_rd_vld_q ? {1'b0, used_rd_q} : 16'd0;
  assign start    = aligned_q ? ((used_cur + ALIGN_M1) & ~ALIGN_M1) : used_cur;
  assign room     = {2'b00, pool_q} - {1'b0, start};
  assign new_used = 15'(start + {4'd0, req_q});

  assign fail_old = fail_rd_vld_q ? fail_rd_q : 3'd0;
  assign fail_inc = (fail_old == 3'(FAIL_MAX)) ? fail_old : (fail_old + 3'd1);

  assign limit     = (pool_q < 15'(SMALL_LIMIT)) ? pool_q : 15'(SMALL_LIMIT);
  assign is_alloc  = (in_data_i.operation == OP_ALIGNED) ||
                     (in_data_i.operation == OP_UNALIGNED);
  assign too_large = (in_data_i.request_bytes > {1'b0, limit});

  assign blk_ext = {1'b0, blk_q};
  assign cur_ext = {1'b0, cur_q};
  assign app_idx = cnt_q[IDX_W-1:0];

  assign sts_o.start_search = is_alloc && !too_large;
  assign sts_o.fits         = !room[16] && (room[15:0] >= {4'd0, req_q});
  assign sts_o.last         = (blk_ext + CNT_W'(1)) >= cnt_q;
  assign sts_o.table_full   = (cnt_q >= CNT_W'(MAX_BLOCKS));
  assign sts_o.walk_none    = (cur_ext + CNT_W'(1)) >= cnt_q;
  assign sts_o.walk_last    = (blk_ext + CNT_W'(2)) >= cnt_q;
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------- writes
  always_comb begin
    used_we = cmd_i.grant || cmd_i.append;
    used_wa = cmd_i.grant ? blk_q : app_idx;
    used_wd = cmd_i.grant ? new_used : {3'd0, req_q};
    fail_we = cmd_i.walk_step || cmd_i.append;
    fail_wa = cmd_i.walk_step ? blk_q : app_idx;
    fail_wd = cmd_i.walk_step ? fail_inc : 3'd0;

    used_vld_d = used_vld_q;
    if (cmd_i.accept && (in_data_i.operation == OP_RESET)) begin
      used_vld_d = '0;
    end
    if (used_we) begin
      used_vld_d[used_wa] = 1'b1;
    end
    fail_vld_d = fail_vld_q;
    if (fail_we) begin
      fail_vld_d[fail_wa] = 1'b1;
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    pool_d      = pool_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    blk_d       = blk_q;
    ncur_d      = ncur_q;
    aligned_d   = aligned_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      pool_d = cfg_data_i;
    end
    if (cmd_i.accept) begin
      aligned_d = (in_data_i.operation == OP_ALIGNED);
      req_d     = in_data_i.request_bytes[11:0];
      blk_d     = cur_q;
      res_d     = '0;
      if (is_alloc && too_large) begin
        res_d.status = ST_TOO_LARGE;
      end
    end
    if (cmd_i.step_next) begin
      blk_d = blk_q + IDX_W'(1);
    end
    if (cmd_i.grant) begin
      res_d.status       = ST_OK;
      res_d.block_index  = 6'(blk_q);
      res_d.byte_offset  = start[13:0];
      res_d.opened_block = 1'b0;
    end
    if (cmd_i.full) begin
      res_d        = '0;
      res_d.status = ST_NO_BLOCK;
    end
    if (cmd_i.walk_init) begin
      blk_d  = cur_q;
      ncur_d = cur_q;
    end
    if (cmd_i.walk_step) begin
      blk_d = blk_q + IDX_W'(1);
      // A block that has failed too often is skipped by later searches.
      if (fail_old > 3'(FAIL_THRESHOLD)) begin
        ncur_d = blk_q + IDX_W'(1);
      end
    end
    if (cmd_i.append) begin
      cnt_d              = cnt_q + CNT_W'(1);
      cur_d              = ncur_q;
      res_d.status       = ST_OK;
      res_d.block_index  = 6'(app_idx);
      res_d.byte_offset  = '0;
      res_d.opened_block = 1'b1;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q        <= POOL_SIZE_RST;
      cur_q         <= '0;
      cnt_q         <= CNT_W'(1);
      used_vld_q    <= '0;
      fail_vld_q    <= '0;
      used_rd_vld_q <= 1'b0;
      fail_rd_vld_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      pool_q        <= pool_d;
      cur_q         <= cur_d;
      cnt_q         <= cnt_d;
      used_vld_q    <= used_vld_d;
      fail_vld_q    <= fail_vld_d;
      used_rd_vld_q <= used_vld_q[blk_q];
      fail_rd_vld_q <= fail_vld_q[blk_q];
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q     <= blk_d;
    ncur_q    <= ncur_d;
    aligned_q <= aligned_d;
    req_q     <= req_d;
    res_q     <= res_d;
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- checks
  `ASSERT_ALWAYS(a_cur_below_count, clk_i, rst_ni, cur_ext < cnt_q)
  `ASSERT_ALWAYS(a_count_range, clk_i, rst_ni, (cnt_q != '0) && (cnt_q <= CNT_W'(MAX_BLOCKS)))
  `ASSERT_IMPLY(a_grant_fits, clk_i, rst_ni, cmd_i.grant, sts_o.fits)
  `ASSERT_IMPLY(a_append_room, clk_i, rst_ni, cmd_i.append, !sts_o.table_full)

endmodule

[src/block_bump_pool_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bump_pool_allocator
// Bump-pointer pool allocator over a table of equal-sized blocks.
//
//   channel   direction  handshake        payload
//   in        input      valid / stall    in_item_t  (operation, request_bytes)
//   out       output     valid / stall    out_item_t (status, block_index, ...)
//   cfg       input      valid / ready    pool_size, 15 bits
//
// A reset, no-op or too-large request goes straight to the response. An
// allocation reads and checks each block searched, and when no block fits
// it walks the fail counts of the blocks passed and then appends a block.
// Each block is read, then checked, through the registered table read port.
// Reset leaves one empty head block; the tables need no clearing pass.
// A stalled result sits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module block_bump_pool_allocator
  import bbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  bbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bump pool allocator. A scoreboard class keeps
// its own copy of the block table and predicts every grant. Directed
// requests come first, then random requests over several pool sizes, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
  import bbpa_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 300;
  localparam int PHASE_ITEMS   = 310;
  localparam int MAX_GAP       = 4;
  localparam int NUM_PHASES    = 6;

  class alloc_scoreboard;
    logic [14:0] pool_size;
    logic [14:0] used_off [MAX_BLOCKS_DEF];
    logic [2:0]  fail_cnt [MAX_BLOCKS_DEF];
    int unsigned cur_blk;
    int unsigned n_blocks;
    out_item_t   pending_grants [$];
    int          errors;
    int          status_seen [3];
    int          opened;

    function new();
      pool_size = POOL_SIZE_RST;
      foreach (used_off[i]) begin
        used_off[i] = '0;
        fail_cnt[i] = '0;
      end
      cur_blk  = 0;
      n_blocks = 1;
      errors   = 0;
      opened   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Works out the grant for one accepted request and updates the table.
    function void note_request(in_item_t req);
      out_item_t   res;
      int unsigned lim;
      int unsigned size;
      int unsigned start;
      int unsigned next_cur;
      bit          found;
      res   = '0;
      found = 1'b0;
      size  = req.request_bytes;
      lim   = (pool_size < SMALL_LIMIT) ? pool_size : SMALL_LIMIT;
      if (req.operation == OP_RESET) begin
        foreach (used_off[i]) used_off[i] = '0;
      end else if (req.operation != OP_NOP) begin
        if (size > lim) begin
          res.status = ST_TOO_LARGE;
        end else begin
          for (int unsigned b = cur_blk; b < n_blocks && !found; b++) begin
            start = used_off[b];
            if (req.operation == OP_ALIGNED)
              start = (start + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
            // Guard first so that a block used past a shrunken pool never wraps.
            if (start <= pool_size && pool_size - start >= size) begin
              used_off[b]     = 15'(start + size);
              res.block_index = 6'(b);
              res.byte_offset = 14'(start);
              found           = 1'b1;
            end
          end
          if (!found) begin
            if (n_blocks >= MAX_BLOCKS_DEF) begin
              res.status = ST_NO_BLOCK;
            end else begin
              next_cur = cur_blk;
              for (int unsigned b = cur_blk; b + 1 < n_blocks; b++) begin
                if (fail_cnt[b] > FAIL_THRESHOLD) next_cur = b + 1;
                if (fail_cnt[b] < FAIL_MAX) fail_cnt[b] = fail_cnt[b] + 3'd1;
              end
              used_off[n_blocks] = 15'(size);
              fail_cnt[n_blocks] = '0;
              res.block_index    = 6'(n_blocks);
              res.opened_block   = 1'b1;
              n_blocks           = n_blocks + 1;
              cur_blk            = next_cur;
              opened++;
            end
          end
        end
      end
      pending_grants.push_back(res);
    endfunction

    function void check_grant(out_item_t got);
      out_item_t exp;
      if (pending_grants.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      exp = pending_grants.pop_front();
      status_seen[exp.status]++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.block_index !== exp.block_index) begin
        $error("block_index: expected %0d, got %0d", exp.block_index, got.block_index);
        errors++;
      end
      if (got.byte_offset !== exp.byte_offset) begin
        $error("byte_offset: expected %0d, got %0d", exp.byte_offset, got.byte_offset);
        errors++;
      end
      if (got.opened_block !== exp.opened_block) begin
        $error("opened_block: expected %0d, got %0d", exp.opened_block, got.opened_block);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [14:0] cfg_data_i;

  alloc_scoreboard sb;
  bit              calm;
  int              requests_sent;
  int              cfg_writes;
  int              cycles;

  block_bump_pool_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic in_item_t make_req(logic [1:0] op, logic [15:0] size);
    in_item_t r;
    r.operation     = op;
    r.request_bytes = size;
    return r;
  endfunction

  // Mostly small allocations so that blocks fill up gradually, with
  // occasional table clears, sizes around the limit and wild sizes.
  function automatic in_item_t random_request();
    int unsigned lim;
    int unsigned pick;
    logic [1:0]  op;
    logic [15:0] size;
    lim  = (sb.pool_size < SMALL_LIMIT) ? sb.pool_size : SMALL_LIMIT;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = OP_ALIGNED;
    else if (pick < 92) op = OP_UNALIGNED;
    else if (pick < 97) op = OP_RESET;
    else                op = OP_NOP;
    pick = $urandom_range(0, 99);
    if (pick < 55)      size = 16'($urandom_range(0, lim / 8));
    else if (pick < 75) size = 16'($urandom_range(0, lim));
    else if (pick < 88) size = 16'($urandom_range(lim - 2, lim + 2));
    else                size = 16'($urandom());
    return make_req(op, size);
  endfunction

  task automatic send_request(in_item_t req);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_request(req);
    requests_sent++;
  endtask

  task automatic wait_drained();
    while (sb.pending_grants.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_pool_size(logic [14:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i  <= 1'b0;
    sb.pool_size = value;
    cfg_writes++;
  endtask

  // Result side: a fresh stall length is drawn before each transaction.
  initial begin
    int unsigned hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_grant(out_data_o);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [14:0] phase_sizes [NUM_PHASES];
    sb            = new();
    calm          = 1'b0;
    requests_sent = 0;
    cfg_writes    = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    phase_sizes   = '{15'd16384, 15'd32, 15'd4095, 15'($urandom_range(33, 16383)),
                      15'd4097, 15'($urandom_range(32, 300))};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset pool size.
    send_request(make_req(OP_ALIGNED, 16'd0));
    send_request(make_req(OP_UNALIGNED, 16'd1));
    send_request(make_req(OP_ALIGNED, 16'd5));
    send_request(make_req(OP_UNALIGNED, 16'd4095));
    send_request(make_req(OP_ALIGNED, 16'd4096));
    send_request(make_req(OP_UNALIGNED, 16'hFFFF));
    send_request(make_req(OP_NOP, 16'hFFFF));
    send_request(make_req(OP_RESET, 16'h5A5A));
    send_request(make_req(OP_ALIGNED, 16'd4095));
    // Repeated misses push fail counts past the threshold and move the
    // search start forward.
    repeat (8) send_request(make_req(OP_UNALIGNED, 16'd4095));
    send_request(make_req(OP_ALIGNED, 16'd0));
    send_request(make_req(OP_ALIGNED, 16'd17));
    send_request(make_req(OP_RESET, 16'd0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_pool_size(phase_sizes[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
        if (p == 1 && i == PHASE_ITEMS / 2) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          wait_drained();
        end
        send_request(random_request());
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests over %0d pool size settings: %0d ok, %0d too large, %0d table full.",
             requests_sent, cfg_writes + 1, sb.status_seen[ST_OK],
             sb.status_seen[ST_TOO_LARGE], sb.status_seen[ST_NO_BLOCK]);
    $display("Opened %0d blocks; the table ended with %0d of %0d in use.",
             sb.opened, sb.n_blocks, MAX_BLOCKS_DEF);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
